### src/pidlv_pkg.sv
// shared types and constants for the pid level valve controller
package pidlv_pkg;

    // field and register widths
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned GAIN_W     = 8;
    localparam int unsigned ANGLE_W    = 8;
    localparam int unsigned STEP_W     = 8;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned SUM_W      = 40;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // level difference is scaled by 1/25600 = 1/(25 * 2^10), rounded half away from zero
    localparam int unsigned DIV_SHIFT      = 10;
    localparam int unsigned DIV_ODD        = 25;
    localparam int unsigned LEVEL_HALF_DIV = 12800;

    // pi in Q30 for the threshold series
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // popcount group size for the angle search
    localparam int unsigned GRP = 8;

    // error sum saturation bounds
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // valve command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 2'd0,
        REG_GAIN_P   = 2'd1,
        REG_GAIN_I   = 2'd2,
        REG_GAIN_D   = 2'd3
    } t_reg_idx;

    // configuration register set
    typedef struct packed {
        logic [LEVEL_W-1:0] setpoint;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
    } t_cfg;

    // setpoint 80 percent in q8.8, gains 10, 1, 3
    localparam t_cfg CFG_RESET = '{
        setpoint: 16'd20480,
        gain_p:   8'd10,
        gain_i:   8'd1,
        gain_d:   8'd3
    };

endpackage

### src/pidlv_err.sv
// error pipeline: level difference scaled to the signed fixed-point error
module pidlv_err
    import pidlv_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [LEVEL_W-1:0]         i_level,
    input  logic [LEVEL_W-1:0]         i_setpoint,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [FRAC_BITS+2:0] o_err,
    output logic signed [FRAC_BITS+2:0] o_prev_err
);

    localparam int unsigned EW = FRAC_BITS + 3;
    localparam int unsigned QW = FRAC_BITS + 2;
    localparam int unsigned NW = LEVEL_W + FRAC_BITS + 1;
    localparam int unsigned MW = NW - DIV_SHIFT;
    localparam int unsigned RW = MW - $clog2(DIV_ODD) + 1;
    localparam longint unsigned RECIP_L = (64'd1 << MW) / DIV_ODD;
    localparam logic [RW-1:0] RECIP = RECIP_L[RW-1:0];

    logic s1_ready, s2_ready, s3_ready;
    logic r1_valid, r2_valid, r3_valid;

    logic                 r1_neg, n_neg;
    logic [LEVEL_W-1:0]   r1_mag, n_mag;
    logic signed [LEVEL_W:0] diff;

    logic                 r2_neg;
    logic [MW-1:0]        r2_m, n_m;
    logic [QW-1:0]        r2_q0, n_q0;
    logic [NW-1:0]        num;
    logic [MW+RW-1:0]     prod;

    logic [MW-1:0]        q25, rem;
    logic [QW-1:0]        q;
    logic signed [EW-1:0] n_err, r3_err, r3_prev, r_last_err;

    // stall chain
    assign s3_ready = !r3_valid || i_ready;
    assign s2_ready = !r2_valid || s3_ready;
    assign s1_ready = !r1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r3_valid;
    assign o_err      = r3_err;
    assign o_prev_err = r3_prev;

    // sign and magnitude of setpoint minus level
    always_comb begin
        diff  = $signed({1'b0, i_setpoint}) - $signed({1'b0, i_level});
        n_neg = diff[LEVEL_W];
        n_mag = diff[LEVEL_W] ? LEVEL_W'(-diff) : LEVEL_W'(diff);
    end

    // scaled numerator and reciprocal estimate of the quotient by 25
    always_comb begin
        num  = (NW'(r1_mag) << FRAC_BITS) + NW'(LEVEL_HALF_DIV);
        n_m  = num[NW-1:DIV_SHIFT];
        prod = (MW+RW)'(n_m) * (MW+RW)'(RECIP);
        n_q0 = prod[MW+QW-1:MW];
    end

    // one step correction, then apply the sign
    always_comb begin
        q25   = (MW'(r2_q0) << 4) + (MW'(r2_q0) << 3) + MW'(r2_q0);
        rem   = r2_m - q25;
        q     = (rem >= MW'(DIV_ODD)) ? r2_q0 + QW'(1) : r2_q0;
        n_err = r2_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    // valid bits and last error state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (s1_ready) begin
                r1_valid <= i_valid && (i_level != '0);
            end
            if (s2_ready) begin
                r2_valid <= r1_valid;
            end
            if (s3_ready) begin
                r3_valid <= r2_valid;
            end
            if (s3_ready && r2_valid) begin
                r_last_err <= n_err;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r1_neg <= n_neg;
            r1_mag <= n_mag;
        end
        if (s2_ready && r1_valid) begin
            r2_neg <= r1_neg;
            r2_m   <= n_m;
            r2_q0  <= n_q0;
        end
        if (s3_ready && r2_valid) begin
            r3_err  <= n_err;
            r3_prev <= r_last_err;
        end
    end

endmodule

### src/pidlv_pid.sv
// pid pipeline: p and d terms, anti-windup error sum, clamped control signal
module pidlv_pid
    import pidlv_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [FRAC_BITS+2:0] i_err,
    input  logic signed [FRAC_BITS+2:0] i_prev_err,
    input  t_cfg                        i_cfg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_neg,
    output logic [FRAC_BITS:0]          o_mag
);

    localparam int unsigned EW = FRAC_BITS + 3;
    localparam int unsigned PW = EW + GAIN_W + 3;
    localparam int unsigned CW = SUM_W + GAIN_W + 1;
    localparam int unsigned UW = CW + 1;
    localparam logic signed [UW-1:0] POS_ONE = UW'(1) << FRAC_BITS;
    localparam logic signed [UW-1:0] NEG_ONE = -POS_ONE;
    localparam logic [FRAC_BITS:0]   MAG_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic s1_ready, s2_ready, s3_ready;
    logic r1_valid, r2_valid, r3_valid;

    logic signed [GAIN_W:0] gp_s, gi_s, gd_s;

    logic signed [EW:0]          n_diffe;
    logic signed [EW+GAIN_W:0]   n_p;
    logic signed [EW+GAIN_W+1:0] n_d;
    logic signed [PW-1:0]        n_pd, r1_pd, r2_pd;
    logic signed [EW-1:0]        r1_err;

    logic signed [SUM_W:0]   sum_w;
    logic signed [SUM_W-1:0] s1, r_es;
    logic signed [CW-1:0]    prod_c, prod_u;
    logic signed [UW-1:0]    cand, u, abs_u;
    logic                    upd;

    logic                 n_neg, r3_neg;
    logic [FRAC_BITS:0]   n_mag, r3_mag;

    assign gp_s = $signed({1'b0, i_cfg.gain_p});
    assign gi_s = $signed({1'b0, i_cfg.gain_i});
    assign gd_s = $signed({1'b0, i_cfg.gain_d});

    // stall chain
    assign s3_ready = !r3_valid || i_ready;
    assign s2_ready = !r2_valid || s3_ready;
    assign s1_ready = !r1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r3_valid;
    assign o_neg    = r3_neg;
    assign o_mag    = r3_mag;

    // proportional plus derivative term
    always_comb begin
        n_diffe = (EW+1)'(i_err) - (EW+1)'(i_prev_err);
        n_p     = (EW+GAIN_W+1)'(i_err) * (EW+GAIN_W+1)'(gp_s);
        n_d     = (EW+GAIN_W+2)'(n_diffe) * (EW+GAIN_W+2)'(gd_s);
        n_pd    = PW'(n_p) + PW'(n_d);
    end

    // anti-windup: take the error into the sum only if the output stays in range
    always_comb begin
        sum_w = (SUM_W+1)'(r_es) + (SUM_W+1)'(r1_err);
        if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
            s1 = sum_w[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            s1 = sum_w[SUM_W-1:0];
        end
        prod_c = CW'(s1) * CW'(gi_s);
        cand   = UW'(r1_pd) + UW'(prod_c);
        upd    = (cand <= POS_ONE) && (cand >= NEG_ONE);
    end

    // control signal, clamped to plus or minus one
    always_comb begin
        prod_u = CW'(r_es) * CW'(gi_s);
        u      = UW'(r2_pd) + UW'(prod_u);
        abs_u  = u[UW-1] ? -u : u;
        if (u > POS_ONE) begin
            n_neg = 1'b0;
            n_mag = MAG_ONE;
        end else if (u < NEG_ONE) begin
            n_neg = 1'b1;
            n_mag = MAG_ONE;
        end else begin
            n_neg = u[UW-1];
            n_mag = abs_u[FRAC_BITS:0];
        end
    end

    // valid bits and error sum state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_es     <= '0;
        end else begin
            if (s1_ready) begin
                r1_valid <= i_valid;
            end
            if (s2_ready) begin
                r2_valid <= r1_valid;
            end
            if (s3_ready) begin
                r3_valid <= r2_valid;
            end
            if (s2_ready && r1_valid && upd) begin
                r_es <= s1;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r1_err <= i_err;
            r1_pd  <= n_pd;
        end
        if (s2_ready && r1_valid) begin
            r2_pd <= r1_pd;
        end
        if (s3_ready && r2_valid) begin
            r3_neg <= n_neg;
            r3_mag <= n_mag;
        end
    end

endmodule

### src/pidlv_angle.sv
// angle pipeline: count arcsine rounding thresholds at or below the control magnitude
module pidlv_angle
    import pidlv_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned ANGLE_RANGE = 100
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_neg,
    input  logic [FRAC_BITS:0]                     i_mag,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [$clog2(ANGLE_RANGE+1):0]  o_angle
);

    localparam int unsigned AW  = $clog2(ANGLE_RANGE + 1);
    localparam int unsigned NG  = (ANGLE_RANGE + GRP - 1) / GRP;
    localparam int unsigned NS  = (NG + GRP - 1) / GRP;
    localparam int unsigned NGP = NS * GRP;
    localparam int unsigned GCW = $clog2(GRP + 1);
    localparam int unsigned SCW = $clog2(GRP * GRP + 1);

    logic s1_ready, s2_ready, s3_ready;
    logic r1_valid, r2_valid, r3_valid;

    logic [NGP*GRP-1:0]  hit;
    logic [GCW-1:0]      n_cnt [NGP];
    logic [GCW-1:0]      r1_cnt [NGP];
    logic [SCW-1:0]      n_sum [NS];
    logic [SCW-1:0]      r2_sum [NS];
    logic                r1_neg, r2_neg;
    logic [AW-1:0]       total;
    logic signed [AW:0]  n_angle, r3_angle;

    // stall chain
    assign s3_ready = !r3_valid || i_ready;
    assign s2_ready = !r2_valid || s3_ready;
    assign s1_ready = !r1_valid || s2_ready;
    assign o_ready  = s1_ready;
    assign o_valid  = r3_valid;
    assign o_angle  = r3_angle;

    // one comparator per threshold sin((2k+1) pi / (4 range)) in q.frac
    for (genvar k = 0; k < NGP * GRP; k++) begin : g_thr
        if (k < ANGLE_RANGE) begin : g_cmp
            localparam longint unsigned X_V =
                (longint'(2 * k + 1) * PI_Q30) / longint'(4 * ANGLE_RANGE);
            // taylor terms of the sine in q30, each product truncated
            localparam longint unsigned X2  = (X_V * X_V) >> 30;
            localparam longint unsigned T1  = ((X_V * X2) >> 30) / 64'd6;
            localparam longint unsigned T2  = ((T1 * X2) >> 30) / 64'd20;
            localparam longint unsigned T3  = ((T2 * X2) >> 30) / 64'd42;
            localparam longint unsigned T4  = ((T3 * X2) >> 30) / 64'd72;
            localparam longint unsigned T5  = ((T4 * X2) >> 30) / 64'd110;
            localparam longint unsigned T6  = ((T5 * X2) >> 30) / 64'd156;
            localparam longint unsigned T7  = ((T6 * X2) >> 30) / 64'd210;
            localparam longint unsigned T8  = ((T7 * X2) >> 30) / 64'd272;
            localparam longint unsigned T9  = ((T8 * X2) >> 30) / 64'd342;
            localparam longint unsigned T10 = ((T9 * X2) >> 30) / 64'd420;
            localparam longint unsigned T11 = ((T10 * X2) >> 30) / 64'd506;
            localparam longint unsigned T12 = ((T11 * X2) >> 30) / 64'd600;
            localparam longint SIN_S =
                longint'(X_V) - longint'(T1) + longint'(T2) - longint'(T3)
                + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                + longint'(T8) - longint'(T9) + longint'(T10) - longint'(T11)
                + longint'(T12);
            localparam longint unsigned SIN_V = (SIN_S < 0) ? 64'd0 : 64'(SIN_S);
            localparam longint unsigned T_V =
                (SIN_V + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            localparam logic [FRAC_BITS:0] THR = T_V[FRAC_BITS:0];
            assign hit[k] = (i_mag >= THR);
        end else begin : g_pad
            assign hit[k] = 1'b0;
        end
    end

    // popcount per group of comparators
    always_comb begin
        for (int g = 0; g < NGP; g++) begin
            n_cnt[g] = '0;
            for (int b = 0; b < GRP; b++) begin
                n_cnt[g] = n_cnt[g] + GCW'(hit[g*GRP+b]);
            end
        end
    end

    // sum of group counts per super group
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_sum[s] = '0;
            for (int j = 0; j < GRP; j++) begin
                n_sum[s] = n_sum[s] + SCW'(r1_cnt[s*GRP+j]);
            end
        end
    end

    // total count with the sign of the control signal
    always_comb begin
        total = '0;
        for (int s = 0; s < NS; s++) begin
            total = total + AW'(r2_sum[s]);
        end
        n_angle = r2_neg ? -$signed({1'b0, total}) : $signed({1'b0, total});
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r1_valid <= i_valid;
            end
            if (s2_ready) begin
                r2_valid <= r1_valid;
            end
            if (s3_ready) begin
                r3_valid <= r2_valid;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r1_neg <= i_neg;
            r1_cnt <= n_cnt;
        end
        if (s2_ready && r1_valid) begin
            r2_neg <= r1_neg;
            r2_sum <= n_sum;
        end
        if (s3_ready && r2_valid) begin
            r3_angle <= n_angle;
        end
    end

endmodule

### src/pid_level_valve_controller_top.sv
// top level of the pid level valve controller: config registers and valve command stage
//
// Takes tank level samples (unsigned q8.8 percent) on the in channel and returns
// a valve angle, the step from the previous angle and an open/close/none command
// on the out channel. Both channels are valid/ready; an item moves when valid and
// ready are high at a clock edge. A zero sample is accepted and gives no result.
// Setpoint and the three gains sit on the cfg channel (index 0 setpoint, 1 p,
// 2 i, 3 d); cfg ready is always high and writes belong to idle periods.
// Throughput is one item per cycle while the receiver does not stall. An
// accepted item passes ten register stages, the first loaded at the accepting
// edge: three of error scaling, three of pid math (the error sum loop closes in
// one stage), three of threshold counting and the output register.
// When the receiver stalls, results back up stage by stage; bubbles still close
// up, and the in channel stops taking items only when every stage is full.
// Reset (synchronous, active low) empties the pipeline, loads the default
// setpoint and gains, clears the error sum and last error, and sets the last
// angle to the full open angle.
module pid_level_valve_controller_top
    import pidlv_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned ANGLE_RANGE = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [LEVEL_W-1:0]    i_level_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [ANGLE_W-1:0] o_valve_angle,
    output logic [CMD_W-1:0]      o_valve_command,
    output logic [STEP_W-1:0]     o_step_size,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned EW = FRAC_BITS + 3;
    localparam int unsigned AW = $clog2(ANGLE_RANGE + 1);
    localparam int unsigned DW = AW + 2;

    t_cfg r_cfg;

    logic                 err_valid, err_ready;
    logic signed [EW-1:0] err, prev_err;
    logic                 pid_valid, pid_ready;
    logic                 pid_neg;
    logic [FRAC_BITS:0]   pid_mag;
    logic                 ang_valid, out_ready;
    logic signed [AW:0]   angle;

    logic signed [AW:0]   r_last_angle;
    logic signed [DW-1:0] delta, abs_delta;
    t_cmd                 n_cmd;
    logic                 r_out_valid;
    logic signed [ANGLE_W-1:0] r_angle;
    t_cmd                 r_cmd;
    logic [STEP_W-1:0]    r_step;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SETPOINT: r_cfg.setpoint <= i_cfg_data[LEVEL_W-1:0];
                REG_GAIN_P:   r_cfg.gain_p   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   r_cfg.gain_i   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   r_cfg.gain_d   <= i_cfg_data[GAIN_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    pidlv_err #(
        .FRAC_BITS (FRAC_BITS)
    ) u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_level    (i_level_sample),
        .i_setpoint (r_cfg.setpoint),
        .o_valid    (err_valid),
        .i_ready    (err_ready),
        .o_err      (err),
        .o_prev_err (prev_err)
    );

    pidlv_pid #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (err_valid),
        .o_ready    (err_ready),
        .i_err      (err),
        .i_prev_err (prev_err),
        .i_cfg      (r_cfg),
        .o_valid    (pid_valid),
        .i_ready    (pid_ready),
        .o_neg      (pid_neg),
        .o_mag      (pid_mag)
    );

    pidlv_angle #(
        .FRAC_BITS   (FRAC_BITS),
        .ANGLE_RANGE (ANGLE_RANGE)
    ) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pid_valid),
        .o_ready (pid_ready),
        .i_neg   (pid_neg),
        .i_mag   (pid_mag),
        .o_valid (ang_valid),
        .i_ready (out_ready),
        .o_angle (angle)
    );

    // output register frees up when empty or when the receiver takes the item
    assign out_ready = !r_out_valid || i_out_ready;

    // step and direction against the previous angle
    always_comb begin
        delta     = DW'(angle) - DW'(r_last_angle);
        abs_delta = delta[DW-1] ? -delta : delta;
        if (delta > 0) begin
            n_cmd = CMD_OPEN;
        end else if (delta < 0) begin
            n_cmd = CMD_CLOSE;
        end else begin
            n_cmd = CMD_NONE;
        end
    end

    // output valid and last angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_angle <= (AW+1)'(ANGLE_RANGE);
        end else begin
            if (out_ready) begin
                r_out_valid <= ang_valid;
            end
            if (out_ready && ang_valid) begin
                r_last_angle <= angle;
            end
        end
    end

    // output payload, angle and step keep their low bits
    always_ff @(posedge i_clk) begin
        if (out_ready && ang_valid) begin
            r_angle <= ANGLE_W'(angle);
            r_cmd   <= n_cmd;
            r_step  <= STEP_W'(abs_delta);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_valve_angle   = r_angle;
    assign o_valve_command = r_cmd;
    assign o_step_size     = r_step;

endmodule
